// File: rtl/ntt_q3329_pkg.sv
// Package for the q=3329 NTT core: action codes, command/status structs,
// modular helpers and the bit-reversed zeta table. No dependencies.
`default_nettype none

package ntt_q3329_pkg;

  localparam int unsigned NCoeffs  = 256;
  localparam int unsigned AddrW    = 8;
  localparam int unsigned CoeffW   = 12;
  localparam logic [11:0] QMod     = 12'd3329;
  localparam logic [11:0] InvScale = 12'd3303;
  // Barrett constant floor(2^24 / 3329)
  localparam logic [12:0] BarrettM = 13'd5039;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  // operand choice for the modular multiplier
  typedef enum logic [1:0] {
    MOP_FWD   = 2'd0,
    MOP_INV   = 2'd1,
    MOP_SCALE = 2'd2
  } mop_e;

  // write data choice for the coefficient store
  typedef enum logic [2:0] {
    WSEL_LOAD    = 3'd0,
    WSEL_FWD_SUM = 3'd1,
    WSEL_FWD_DIF = 3'd2,
    WSEL_INV_SUM = 3'd3,
    WSEL_PROD    = 3'd4
  } wsel_e;

  typedef struct packed {
    logic              rd_en;
    logic [AddrW-1:0]  rd_addr_a;
    logic [AddrW-1:0]  rd_addr_b;
    logic              mul_en;
    mop_e              mop;
    logic [11:0]       zeta;
    logic              red1_en;
    logic              red2_en;
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    wsel_e             wsel;
    logic [11:0]       load_data;
  } dp_cmd_t;

  typedef struct packed {
    logic [11:0] rdata_a;
  } dp_sts_t;

  typedef logic [11:0] zeta_tbl_t [128];

  function automatic logic [11:0] add_mod(input logic [11:0] a, input logic [11:0] b);
    logic [12:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, QMod}) s = s - {1'b0, QMod};
    return s[11:0];
  endfunction

  function automatic logic [11:0] sub_mod(input logic [11:0] a, input logic [11:0] b);
    logic [12:0] s;
    s = {1'b0, a} + {1'b0, QMod} - {1'b0, b};
    if (s >= {1'b0, QMod}) s = s - {1'b0, QMod};
    return s[11:0];
  endfunction

  // zeta k = 17^bitrev7(k) mod q, evaluated at elaboration
  function automatic zeta_tbl_t gen_zetas();
    zeta_tbl_t   tbl;
    int unsigned r;
    int unsigned p;
    for (int k = 0; k < 128; k++) begin
      r = 0;
      for (int b = 0; b < 7; b++) begin
        if (((k >> b) & 1) != 0) r = r | (1 << (6 - b));
      end
      p = 1;
      for (int unsigned e = 0; e < r; e++) begin
        p = (p * 17) % 3329;
      end
      tbl[k] = p[11:0];
    end
    return tbl;
  endfunction

  localparam zeta_tbl_t Zetas = gen_zetas();

endpackage

`default_nettype wire

// File: rtl/ntt_q3329_dp.sv
// Datapath: coefficient store with valid bits, modular multiplier with
// Barrett reduction, butterfly add/sub. Depends on ntt_q3329_pkg.
`default_nettype none

module ntt_q3329_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ntt_q3329_pkg::dp_cmd_t cmd_i,
  output ntt_q3329_pkg::dp_sts_t sts_o
);
  import ntt_q3329_pkg::*;

  logic [11:0]        mem_q [NCoeffs];
  logic [NCoeffs-1:0] vld_q;
  logic [11:0]        ra_q, rb_q;
  logic               va_q, vb_q;
  logic [11:0]        a_val, b_val, mop_val;
  logic [23:0]        prod_q;
  logic [11:0]        ahold_q, sum_q;
  logic [12:0]        est_q;
  logic [36:0]        est_full;
  logic [23:0]        rem_full;
  logic [13:0]        rem;
  logic [11:0]        t_q, wdata;

  // store read, two ports, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      ra_q <= mem_q[cmd_i.rd_addr_a];
      rb_q <= mem_q[cmd_i.rd_addr_b];
    end
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wdata;
    end
  end

  // valid bits: unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        va_q <= vld_q[cmd_i.rd_addr_a];
        vb_q <= vld_q[cmd_i.rd_addr_b];
      end
      if (cmd_i.wr_en) vld_q[cmd_i.wr_addr] <= 1'b1;
    end
  end

  assign a_val = va_q ? ra_q : 12'd0;
  assign b_val = vb_q ? rb_q : 12'd0;

  // multiplier operand
  always_comb begin
    case (cmd_i.mop)
      MOP_FWD:   mop_val = b_val;
      MOP_INV:   mop_val = sub_mod(b_val, a_val);
      MOP_SCALE: mop_val = a_val;
      default:   mop_val = a_val;
    endcase
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q  <= {12'd0, cmd_i.zeta} * {12'd0, mop_val};
      ahold_q <= a_val;
      sum_q   <= add_mod(a_val, b_val);
    end
  end

  // Barrett quotient estimate
  assign est_full = {13'd0, prod_q} * {24'd0, BarrettM};

  always_ff @(posedge clk_i) begin
    if (cmd_i.red1_en) est_q <= est_full[36:24];
  end

  // remainder below 3q, fold down twice
  assign rem_full = prod_q - ({11'd0, est_q} * {12'd0, QMod});
  assign rem      = rem_full[13:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.red2_en) begin
      if (rem >= {1'b0, QMod, 1'b0})  t_q <= 12'(rem - {1'b0, QMod, 1'b0});
      else if (rem >= {2'b0, QMod})   t_q <= 12'(rem - {2'b0, QMod});
      else                            t_q <= rem[11:0];
    end
  end

  // write data select
  always_comb begin
    case (cmd_i.wsel)
      WSEL_LOAD:    wdata = cmd_i.load_data;
      WSEL_FWD_SUM: wdata = add_mod(ahold_q, t_q);
      WSEL_FWD_DIF: wdata = sub_mod(ahold_q, t_q);
      WSEL_INV_SUM: wdata = sum_q;
      WSEL_PROD:    wdata = t_q;
      default:      wdata = t_q;
    endcase
  end

  assign sts_o.rdata_a = a_val;

endmodule

`default_nettype wire

// File: rtl/ntt_q3329_ctrl.sv
// Controller: stream handshake, direction register, layer/group/butterfly
// counters and the sequencing FSM. Depends on ntt_q3329_pkg.
`default_nettype none

module ntt_q3329_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             in_action_i,
  input  logic [7:0]             in_index_i,
  input  logic [11:0]            in_coeff_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_kind_o,
  output logic [11:0]            out_coeff_o,
  output logic [7:0]             out_index_o,
  output ntt_q3329_pkg::dp_cmd_t cmd_o,
  input  ntt_q3329_pkg::dp_sts_t sts_i
);
  import ntt_q3329_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDOUT = 9'b000000010,
    S_BRD   = 9'b000000100,
    S_BMUL  = 9'b000001000,
    S_BRED1 = 9'b000010000,
    S_BRED2 = 9'b000100000,
    S_BWRA  = 9'b001000000,
    S_BWRB  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e      state_q, state_d;
  logic        dir_q;
  logic        run_inv_q, run_inv_d;
  logic        scale_q, scale_d;
  logic [7:0]  len_q, len_d;
  logic [8:0]  start_q, start_d;
  logic [7:0]  j_q, j_d;
  logic [6:0]  k_q, k_d;
  logic [7:0]  idx_q;
  logic        oval_q, okind_q;
  logic [11:0] ocoeff_q;
  logic [7:0]  oidx_q;
  logic        accept;
  logic [8:0]  j_next, grp_end, start_next;
  logic [7:0]  addr_b;
  logic [12:0] load_sub;
  action_e     act;

  assign act        = action_e'(in_action_i);
  assign in_ready_o = (state_q == S_IDLE) && (!oval_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign addr_b     = j_q + len_q;
  assign j_next     = {1'b0, j_q} + 9'd1;
  assign grp_end    = start_q + {1'b0, len_q};
  assign start_next = start_q + {len_q, 1'b0};
  assign load_sub   = {1'b0, in_coeff_i} - {1'b0, QMod};

  // direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dir_q <= 1'b0;
    else if (cfg_we_i) dir_q <= cfg_wdata_i;
  end

  // sequencing
  always_comb begin
    state_d   = state_q;
    run_inv_d = run_inv_q;
    scale_d   = scale_q;
    len_d     = len_q;
    start_d   = start_q;
    j_d       = j_q;
    k_d       = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && act == ACT_READ) state_d = S_RDOUT;
        if (accept && act == ACT_RUN) begin
          state_d   = S_BRD;
          run_inv_d = dir_q;
          scale_d   = 1'b0;
          len_d     = dir_q ? 8'd2 : 8'd128;
          k_d       = dir_q ? 7'd127 : 7'd1;
          start_d   = '0;
          j_d       = '0;
        end
      end
      S_RDOUT: state_d = S_IDLE;
      S_BRD:   state_d = S_BMUL;
      S_BMUL:  state_d = S_BRED1;
      S_BRED1: state_d = S_BRED2;
      S_BRED2: state_d = S_BWRA;
      S_BWRA: begin
        if (!scale_q) state_d = S_BWRB;
        else if (j_q == 8'hFF) state_d = S_DONE;
        else begin
          j_d     = j_next[7:0];
          state_d = S_BRD;
        end
      end
      S_BWRB: begin
        state_d = S_BRD;
        if (j_next != grp_end) begin
          j_d = j_next[7:0];
        end else begin
          k_d = run_inv_q ? k_q - 7'd1 : k_q + 7'd1;
          if (!start_next[8]) begin
            start_d = start_next;
            j_d     = start_next[7:0];
          end else begin
            start_d = '0;
            j_d     = '0;
            if (!run_inv_q) begin
              if (len_q == 8'd2) state_d = S_DONE;
              else len_d = len_q >> 1;
            end else begin
              if (len_q == 8'd128) scale_d = 1'b1;
              else len_d = len_q << 1;
            end
          end
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      run_inv_q <= 1'b0;
      scale_q   <= 1'b0;
      len_q     <= '0;
      start_q   <= '0;
      j_q       <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      run_inv_q <= run_inv_d;
      scale_q   <= scale_d;
      len_q     <= len_d;
      start_q   <= start_d;
      j_q       <= j_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) idx_q <= in_index_i;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (state_q == S_RDOUT || state_q == S_DONE) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RDOUT) begin
      okind_q  <= 1'b0;
      ocoeff_q <= sts_i.rdata_a;
      oidx_q   <= idx_q;
    end else if (state_q == S_DONE) begin
      okind_q  <= 1'b1;
      ocoeff_q <= '0;
      oidx_q   <= '0;
    end
  end

  assign out_valid_o = oval_q;
  assign out_kind_o  = okind_q;
  assign out_coeff_o = ocoeff_q;
  assign out_index_o = oidx_q;

  // datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.mop       = scale_q ? MOP_SCALE : (run_inv_q ? MOP_INV : MOP_FWD);
    cmd_o.zeta      = scale_q ? InvScale : Zetas[k_q];
    cmd_o.wsel      = WSEL_LOAD;
    cmd_o.load_data = load_sub[12] ? in_coeff_i : load_sub[11:0];
    cmd_o.rd_addr_a = j_q;
    cmd_o.rd_addr_b = addr_b;
    cmd_o.wr_addr   = j_q;
    if (state_q == S_IDLE) begin
      cmd_o.rd_addr_a = in_index_i;
      cmd_o.rd_en     = accept && act == ACT_READ;
      cmd_o.wr_addr   = in_index_i;
      cmd_o.wr_en     = accept && act == ACT_LOAD;
    end
    if (state_q == S_BRD)   cmd_o.rd_en   = 1'b1;
    if (state_q == S_BMUL)  cmd_o.mul_en  = 1'b1;
    if (state_q == S_BRED1) cmd_o.red1_en = 1'b1;
    if (state_q == S_BRED2) cmd_o.red2_en = 1'b1;
    if (state_q == S_BWRA) begin
      cmd_o.wr_en = 1'b1;
      cmd_o.wsel  = scale_q ? WSEL_PROD : (run_inv_q ? WSEL_INV_SUM : WSEL_FWD_SUM);
    end
    if (state_q == S_BWRB) begin
      cmd_o.wr_en   = 1'b1;
      cmd_o.wr_addr = addr_b;
      cmd_o.wsel    = run_inv_q ? WSEL_PROD : WSEL_FWD_DIF;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ntt_forward_inverse_q3329_core.sv
// Top level of the ML-KEM NTT core (q=3329, 256 coefficients).
// Depends on ntt_q3329_pkg, ntt_q3329_ctrl and ntt_q3329_dp.
//
//  channel  | signals                  | request contents
//  ---------+--------------------------+---------------------------------------
//  s_axis   | tvalid tready tdata tuser| action; index, coeff_in
//  m_axis   | tvalid tready tdata tuser| kind; coeff_out, index_out
//  cfg      | cfg_we_i cfg_wdata_i     | direction (0 fwd, 1 inverse)
//
// Load: written to the store on acceptance. Read: registered store read,
// then the result register. Transform: 896 butterflies, each a store read,
// a multiply, two Barrett steps and two store writes; inverse adds 256
// scalings of one write each. The store has a single write port.
// Reset clears direction and marks all coefficients zero via valid bits.
// Input is held off while a result waits and output is stalled.
`default_nettype none

module ntt_forward_inverse_q3329_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] index, [19:8] coeff_in, [23:20] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [11:0] coeff_out, [19:12] index_out, [23:20] zero
  output logic        m_axis_tuser   // [0] kind
);
  import ntt_q3329_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [11:0] coeff_out;
  logic [7:0]  index_out;

  ntt_q3329_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_index_i  (s_axis_tdata[7:0]),
    .in_coeff_i  (s_axis_tdata[19:8]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_coeff_o (coeff_out),
    .out_index_o (index_out),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ntt_q3329_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  assign m_axis_tdata = {4'd0, index_out, coeff_out};

endmodule

`default_nettype wire

// File: rtl/ntt_q3329_chk.sv
// Port-level checker for the NTT core, bound to the top level.
// Depends on ntt_q3329_pkg and ntt_forward_inverse_q3329_core.
`default_nettype none

module ntt_q3329_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("result changed while stalled");

  // no new request taken while a result is stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready while output stalled");

  // a read request shows its index once the store read and result register are through
  a_read_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ntt_q3329_pkg::ACT_READ |=> ##1
      m_axis_tvalid && !m_axis_tuser && m_axis_tdata[19:12] == $past(s_axis_tdata[7:0], 2))
    else $error("read result missing or wrong index");

  // a finished marker carries zero data
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
    else $error("finished result with nonzero data");

endmodule

bind ntt_forward_inverse_q3329_core ntt_q3329_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
